// ----- sv/sps_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 puzzle package
// Shared types, round constants and SHA-256 helper functions.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned NumCells  = 16;

  typedef enum logic {
    CMD_HASH   = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_e;

  typedef struct packed {
    logic        command;
    logic [31:0] nonce;
    logic [31:0] threshold;
    logic [31:0] target_address;
    logic [31:0] target_port_word;
    logic [7:0]  puzzle_kind;
  } req_t;

  typedef struct packed {
    logic [31:0] value;
    logic        found;
  } rsp_t;

  // Working variables a..h
  typedef struct packed {
    logic [31:0] a, b, c, d, e, f, g, h;
  } wv_t;

  // Control from the sequencer to the round core
  typedef struct packed {
    logic       load;
    logic       run;
    logic [5:0] round;
  } core_ctl_t;

  localparam logic [31:0] H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] KConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] bswap(logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

// ----- sv/sps_wcell.sv -----
// ----------------------------------------------------------------------------
// SHA-256 schedule cell
// One slot of the 16-word message schedule window; shifts to its neighbor.
// ----------------------------------------------------------------------------
module sps_wcell (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic        shift_i,
  input  logic [31:0] load_word_i,
  input  logic [31:0] prev_word_i,
  output logic [31:0] word_o
);

  logic [31:0] word_q;

  // Payload register: load block word or take neighbor word
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      word_q <= load_word_i;
    end else if (shift_i) begin
      word_q <= prev_word_i;
    end
  end

  assign word_o = word_q;

endmodule

// ----- sv/sps_core.sv -----
// ----------------------------------------------------------------------------
// SHA-256 round core
// Chain of schedule cells feeding one compression round per cycle.
// ----------------------------------------------------------------------------
module sps_core (
  input  logic              clk_i,
  input  sps_pkg::core_ctl_t ctl_i,
  input  logic [31:0]       nonce_i,
  input  logic [31:0]       addr_i,
  input  logic [31:0]       port_i,
  input  logic [7:0]        kind_i,
  output logic [31:0]       fold_o
);

  logic [31:0]  blk  [sps_pkg::NumCells];
  logic [31:0]  win  [sps_pkg::NumCells];
  logic [31:0]  w_new, s0, s1, t1, t2;
  sps_pkg::wv_t wv_q, wv_d;
  logic [31:0]  hs [8];

  // Padded block words for the 13-byte message
  always_comb begin
    for (int i = 0; i < sps_pkg::NumCells; i++) begin
      blk[i] = '0;
    end
    blk[0]  = sps_pkg::bswap(nonce_i);
    blk[1]  = sps_pkg::bswap(addr_i);
    blk[2]  = sps_pkg::bswap(port_i);
    blk[3]  = {kind_i, 8'h80, 16'h0000};
    blk[15] = 32'd104;
  end

  // Schedule expansion from the window; win[0] is the word of this round
  always_comb begin
    s0 = sps_pkg::rotr(win[1], 7) ^ sps_pkg::rotr(win[1], 18) ^ (win[1] >> 3);
    s1 = sps_pkg::rotr(win[14], 17) ^ sps_pkg::rotr(win[14], 19) ^ (win[14] >> 10);
    w_new = win[0] + s0 + win[9] + s1;
  end

  // Row of cells; the tail takes the expanded word
  for (genvar g = 0; g < sps_pkg::NumCells; g++) begin : g_cell
    logic [31:0] prev;
    if (g == sps_pkg::NumCells - 1) begin : g_tail
      assign prev = w_new;
    end else begin : g_mid
      assign prev = win[g + 1];
    end
    sps_wcell u_cell (
      .clk_i      (clk_i),
      .load_i     (ctl_i.load),
      .shift_i    (ctl_i.run),
      .load_word_i(blk[g]),
      .prev_word_i(prev),
      .word_o     (win[g])
    );
  end

  // One compression round
  always_comb begin
    t1 = wv_q.h + (sps_pkg::rotr(wv_q.e, 6) ^ sps_pkg::rotr(wv_q.e, 11) ^
         sps_pkg::rotr(wv_q.e, 25)) + ((wv_q.e & wv_q.f) ^ (~wv_q.e & wv_q.g)) +
         sps_pkg::KConst[ctl_i.round] + win[0];
    t2 = (sps_pkg::rotr(wv_q.a, 2) ^ sps_pkg::rotr(wv_q.a, 13) ^
         sps_pkg::rotr(wv_q.a, 22)) +
         ((wv_q.a & wv_q.b) ^ (wv_q.a & wv_q.c) ^ (wv_q.b & wv_q.c));
    wv_d = wv_q;
    if (ctl_i.load) begin
      wv_d = {sps_pkg::H0[0], sps_pkg::H0[1], sps_pkg::H0[2], sps_pkg::H0[3],
              sps_pkg::H0[4], sps_pkg::H0[5], sps_pkg::H0[6], sps_pkg::H0[7]};
    end else if (ctl_i.run) begin
      wv_d = {t1 + t2, wv_q.a, wv_q.b, wv_q.c, wv_q.d + t1, wv_q.e, wv_q.f, wv_q.g};
    end
  end

  always_ff @(posedge clk_i) begin
    wv_q <= wv_d;
  end

  // Final add and fold to 32 bits
  always_comb begin
    logic [31:0] x;
    hs[0] = sps_pkg::H0[0] + wv_q.a;
    hs[1] = sps_pkg::H0[1] + wv_q.b;
    hs[2] = sps_pkg::H0[2] + wv_q.c;
    hs[3] = sps_pkg::H0[3] + wv_q.d;
    hs[4] = sps_pkg::H0[4] + wv_q.e;
    hs[5] = sps_pkg::H0[5] + wv_q.f;
    hs[6] = sps_pkg::H0[6] + wv_q.g;
    hs[7] = sps_pkg::H0[7] + wv_q.h;
    fold_o = '0;
    for (int i = 0; i < 4; i++) begin
      x = hs[2*i] ^ hs[2*i+1];
      fold_o[31-8*i -: 8] = x[31:24] ^ x[23:16] ^ x[15:8] ^ x[7:0];
    end
  end

endmodule

// ----- sv/sha256_puzzle_nonce_search.sv -----
// ----------------------------------------------------------------------------
// SHA-256 puzzle nonce search
// Hashes one nonce or searches nonces for a folded hash below a threshold.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_i and raise start_i while busy_o is low; the item is taken at
//   that edge and busy_o rises the next cycle.
//   A hash item (command 0) passes through the engine in order: a load state,
//   64 rounds of the single round unit fed by a 16-cell schedule row, a fold
//   state. The result is registered onto rsp_o as the fold state ends.
//   A search repeats these steps for each nonce tried, from nonce 1 upward, and stops
//   at the first folded hash below the threshold or after nonce 2^32-1.
//   A search with a zero threshold puts its result on rsp_o in the cycle
//   right after the accepting edge.
//   The result sits on rsp_o for one cycle with done_o high; the receiver
//   cannot stall, so it must capture it then. busy_o falls with done_o, so
//   a new item is accepted only after done_o has fallen.
//   One item at a time; the round unit sets the rate.
//   Reset (rst_ni low, asynchronous) returns the sequencer to idle and
//   clears the counter; any item in flight is dropped.
// ----------------------------------------------------------------------------
module sha256_puzzle_nonce_search (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  sps_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output sps_pkg::rsp_t rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_FOLD
  } state_e;

  state_e             state_q;
  logic [5:0]         round_q;
  logic [31:0]        cand_q;
  logic               search_q;
  sps_pkg::req_t      req_q;
  logic               done_q;
  sps_pkg::rsp_t      rsp_q;
  sps_pkg::core_ctl_t ctl;
  logic [31:0]        fold;
  logic               hit;

  assign ctl.load  = (state_q == ST_LOAD);
  assign ctl.run   = (state_q == ST_RUN);
  assign ctl.round = round_q;

  sps_core u_core (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .nonce_i(cand_q),
    .addr_i (req_q.target_address),
    .port_i (req_q.target_port_word),
    .kind_i (req_q.puzzle_kind),
    .fold_o (fold)
  );

  assign hit = fold < req_q.threshold;

  // Sequencer with registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      round_q  <= '0;
      cand_q   <= '0;
      search_q <= 1'b0;
      done_q   <= 1'b0;
      req_q    <= '0;
      rsp_q    <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          // no item is taken while the previous result is still shown
          if (start_i && !done_q) begin
            req_q    <= req_i;
            search_q <= (req_i.command == sps_pkg::CMD_SEARCH);
            if (req_i.command == sps_pkg::CMD_SEARCH) begin
              cand_q <= 32'd1;
              if (req_i.threshold == '0) begin
                done_q  <= 1'b1;
                rsp_q   <= '0;
                state_q <= ST_IDLE;
              end else begin
                state_q <= ST_LOAD;
              end
            end else begin
              cand_q  <= req_i.nonce;
              state_q <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          round_q <= '0;
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          round_q <= round_q + 6'd1;
          if (round_q == 6'(sps_pkg::NumRounds - 1)) begin
            state_q <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          if (!search_q) begin
            done_q  <= 1'b1;
            rsp_q   <= '{value: fold, found: hit};
            state_q <= ST_IDLE;
          end else if (hit) begin
            done_q  <= 1'b1;
            rsp_q   <= '{value: cand_q, found: 1'b1};
            state_q <= ST_IDLE;
          end else if (cand_q == 32'hffffffff) begin
            done_q  <= 1'b1;
            rsp_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            cand_q  <= cand_q + 32'd1;
            state_q <= ST_LOAD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != ST_IDLE) || done_q;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Checks
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held");
  a_search_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && search_q) |-> cand_q != '0) else $error("nonce zero");
  a_found_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && search_q && rsp_q.found) |-> rsp_q.value != '0)
    else $error("found zero");
  a_fold_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FOLD) |-> $past(state_q == ST_RUN)) else $error("fold order");

endmodule
